// File: design/sdis_pkg.sv
// shared types, codes and constants of the signed decimal integer scanner
package sdis_pkg;

	localparam longint unsigned MAX_CHARS = 64'd65535;
	localparam logic [15:0] POS_LIMIT = (MAX_CHARS < 64'd65535) ? 16'(MAX_CHARS) : 16'hFFFF;

	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);

	localparam logic [63:0] SIGNED_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] SIGNED_MIN_MAG = 64'h8000_0000_0000_0000;
	localparam logic [63:0] WRAP_LIMIT = 64'd1844674407370955161;

	localparam logic [20:0] CP_ZERO = 21'h30;
	localparam logic [20:0] CP_NINE = 21'h39;
	localparam logic [20:0] CP_PLUS = 21'h2B;
	localparam logic [20:0] CP_MINUS = 21'h2D;

	localparam logic [1:0] ST_VALID = 2'd0;
	localparam logic [1:0] ST_TOO_LARGE = 2'd1;
	localparam logic [1:0] ST_INVALID = 2'd2;
	localparam logic [1:0] ST_OVERFLOW = 2'd3;

	localparam logic CMD_CHAR = 1'b0;
	localparam logic CMD_END = 1'b1;

	typedef enum logic [2:0] {
		KIND_DIGIT = 3'd0,
		KIND_PLUS = 3'd1,
		KIND_MINUS = 3'd2,
		KIND_OTHER = 3'd3,
		KIND_END = 3'd4
	} kind_t;

	typedef struct packed {
		logic cmd;
		logic [20:0] code_point;
	} in_word_t;

	typedef struct packed {
		kind_t kind;
		logic [3:0] digit;
	} cls_word_t;

	typedef struct packed {
		logic [1:0] status;
		logic trailing_garbage;
		logic [63:0] number_bits;
		logic [15:0] consumed;
	} out_word_t;

endpackage

// File: design/signed_decimal_integer_scanner_unit.sv
// top level of the signed decimal integer scanner
// Takes one character word per cycle while not full (optional sign, then decimal
// digits, then an end word) and gives one result word per string: status,
// trailing-garbage flag, 64-bit two's complement value and consumed count.
// Sustained rate is one input word per clock while the result queue has room; it
// is set by the back stage, which does the times-ten add and wrap check of the
// 64-bit accumulator combinationally. The back stage acts on a queued word once
// the result queue has room; the result of the word that ends a scan is registered
// into the result queue, which drives the result ports. Front queue holds four words
// and the result queue two, so either side may stall without blocking the other.
module signed_decimal_integer_scanner_unit (
	input logic clk,
	input logic arst_n,
	input logic push,
	output logic full,
	input sdis_pkg::in_word_t in_word,
	output logic empty,
	input logic pop,
	output sdis_pkg::out_word_t out_word
);

	logic q_valid;
	logic q_pop;
	sdis_pkg::cls_word_t q_word;

	sdis_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.in_word(in_word),
		.q_valid(q_valid),
		.q_pop(q_pop),
		.q_word(q_word)
	);

	sdis_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_valid(q_valid),
		.q_pop(q_pop),
		.q_word(q_word),
		.empty(empty),
		.pop(pop),
		.out_word(out_word)
	);

endmodule

// File: design/sdis_front.sv
// front part: classifies incoming characters and queues them for the back part
module sdis_front (
	input logic clk,
	input logic arst_n,
	input logic push,
	output logic full,
	input sdis_pkg::in_word_t in_word,
	output logic q_valid,
	input logic q_pop,
	output sdis_pkg::cls_word_t q_word
);

	sdis_pkg::cls_word_t mem [sdis_pkg::QUEUE_DEPTH];
	logic [sdis_pkg::QUEUE_AW-1:0] wptr_q;
	logic [sdis_pkg::QUEUE_AW-1:0] rptr_q;
	logic [sdis_pkg::QUEUE_AW:0] count_q;
	sdis_pkg::cls_word_t cls;
	logic accept;
	logic take;

	always_comb begin
		cls.digit = in_word.code_point[3:0];
		if (in_word.cmd == sdis_pkg::CMD_END) begin
			cls.kind = sdis_pkg::KIND_END;
		end else if (in_word.code_point >= sdis_pkg::CP_ZERO &&
				in_word.code_point <= sdis_pkg::CP_NINE) begin
			cls.kind = sdis_pkg::KIND_DIGIT;
		end else if (in_word.code_point == sdis_pkg::CP_PLUS) begin
			cls.kind = sdis_pkg::KIND_PLUS;
		end else if (in_word.code_point == sdis_pkg::CP_MINUS) begin
			cls.kind = sdis_pkg::KIND_MINUS;
		end else begin
			cls.kind = sdis_pkg::KIND_OTHER;
		end
	end

	assign full = (count_q == (sdis_pkg::QUEUE_AW+1)'(sdis_pkg::QUEUE_DEPTH));
	assign accept = push && !full;
	assign q_valid = (count_q != '0);
	assign take = q_pop && q_valid;
	assign q_word = mem[rptr_q];

	always_ff @(posedge clk) begin
		if (accept) begin
			mem[wptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			count_q <= '0;
		end else begin
			if (accept) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (take) begin
				rptr_q <= rptr_q + 1'b1;
			end
			count_q <= count_q + (sdis_pkg::QUEUE_AW+1)'(accept)
				- (sdis_pkg::QUEUE_AW+1)'(take);
		end
	end

endmodule

// File: design/sdis_back.sv
// back part: scan state, times-ten accumulation, result build and result queue
module sdis_back (
	input logic clk,
	input logic arst_n,
	input logic q_valid,
	output logic q_pop,
	input sdis_pkg::cls_word_t q_word,
	output logic empty,
	input logic pop,
	output sdis_pkg::out_word_t out_word
);

	typedef enum logic [2:0] {
		PH_INIT = 3'b001,
		PH_SIGN = 3'b010,
		PH_VALUE = 3'b100
	} phase_t;

	phase_t phase_q;
	logic negative_q;
	logic [63:0] acc_q;
	logic [15:0] pos_q;
	logic finished_q;

	sdis_pkg::out_word_t omem [2];
	logic wptr_q;
	logic rptr_q;
	logic [1:0] ocount_q;

	logic go;
	logic pop_acc;
	logic emit;
	logic by_char;
	logic [15:0] pos_adv;
	logic [15:0] pos_back1;
	logic [63:0] acc_x10;
	logic wraps;
	sdis_pkg::out_word_t conc;
	sdis_pkg::out_word_t res;

	phase_t phase_d;
	logic negative_d;
	logic [63:0] acc_d;
	logic [15:0] pos_d;
	logic finished_d;

	assign empty = (ocount_q == 2'd0);
	assign pop_acc = pop && !empty;
	assign go = q_valid && ((ocount_q != 2'd2) || pop);
	assign q_pop = go;
	assign out_word = omem[rptr_q];

	assign by_char = (q_word.kind != sdis_pkg::KIND_END);
	assign pos_adv = (pos_q < sdis_pkg::POS_LIMIT) ? pos_q + 16'd1 : pos_q;
	assign pos_back1 = (pos_q != 16'd0) ? pos_q - 16'd1 : 16'd0;
	assign acc_x10 = {acc_q[60:0], 3'b000} + {acc_q[62:0], 1'b0} + {60'd0, q_word.digit};
	assign wraps = (acc_q > sdis_pkg::WRAP_LIMIT) ||
		(acc_q == sdis_pkg::WRAP_LIMIT && q_word.digit > 4'd5);

	// outcome when the scan ends at a stop character or the end marker
	always_comb begin
		conc.trailing_garbage = 1'b0;
		conc.number_bits = '0;
		conc.consumed = pos_q;
		conc.status = sdis_pkg::ST_VALID;
		case (phase_q)
			PH_INIT: begin
				conc.status = sdis_pkg::ST_INVALID;
			end
			PH_SIGN: begin
				conc.status = sdis_pkg::ST_INVALID;
				conc.consumed = pos_back1;
			end
			default: begin
				if (!negative_q) begin
					conc.status = (acc_q > sdis_pkg::SIGNED_MAX) ?
						sdis_pkg::ST_TOO_LARGE : sdis_pkg::ST_VALID;
					conc.trailing_garbage = by_char;
					conc.number_bits = acc_q;
				end else if (acc_q > sdis_pkg::SIGNED_MIN_MAG) begin
					conc.status = sdis_pkg::ST_OVERFLOW;
					conc.consumed = pos_back1;
				end else begin
					conc.trailing_garbage = by_char;
					conc.number_bits = 64'd0 - acc_q;
				end
			end
		endcase
	end

	always_comb begin
		phase_d = phase_q;
		negative_d = negative_q;
		acc_d = acc_q;
		pos_d = pos_q;
		finished_d = finished_q;
		emit = 1'b0;
		res = conc;
		if (q_word.kind == sdis_pkg::KIND_END) begin
			emit = !finished_q;
			phase_d = PH_INIT;
			negative_d = 1'b0;
			acc_d = '0;
			pos_d = '0;
			finished_d = 1'b0;
		end else if (!finished_q) begin
			case (q_word.kind)
				sdis_pkg::KIND_DIGIT: begin
					pos_d = pos_adv;
					if (wraps) begin
						finished_d = 1'b1;
						emit = 1'b1;
						res.status = sdis_pkg::ST_OVERFLOW;
						res.trailing_garbage = 1'b0;
						res.number_bits = '0;
						res.consumed = (pos_adv >= 16'd2) ? pos_adv - 16'd2 : 16'd0;
					end else begin
						acc_d = acc_x10;
						phase_d = PH_VALUE;
					end
				end
				sdis_pkg::KIND_PLUS, sdis_pkg::KIND_MINUS: begin
					if (phase_q == PH_INIT) begin
						pos_d = pos_adv;
						phase_d = PH_SIGN;
						negative_d = (q_word.kind == sdis_pkg::KIND_MINUS);
					end else begin
						finished_d = 1'b1;
						emit = 1'b1;
					end
				end
				default: begin
					finished_d = 1'b1;
					emit = 1'b1;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_INIT;
			negative_q <= 1'b0;
			acc_q <= '0;
			pos_q <= '0;
			finished_q <= 1'b0;
		end else if (go) begin
			phase_q <= phase_d;
			negative_q <= negative_d;
			acc_q <= acc_d;
			pos_q <= pos_d;
			finished_q <= finished_d;
		end
	end

	always_ff @(posedge clk) begin
		if (go && emit) begin
			omem[wptr_q] <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			ocount_q <= 2'd0;
		end else begin
			if (go && emit) begin
				wptr_q <= !wptr_q;
			end
			if (pop_acc) begin
				rptr_q <= !rptr_q;
			end
			ocount_q <= ocount_q + 2'(go && emit) - 2'(pop_acc);
		end
	end

endmodule
